// ===== rtl/core/tmv_pkg.sv =====
`timescale 1ns / 1ps

package tmv_pkg;

    localparam int DEF_MAX_ROWS  = 16;
    localparam int DEF_MAX_COLS  = 16;
    localparam int DEF_FRAC_BITS = 16;

    localparam int RESULT_LIMIT = 16;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int OP_W         = 2;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(16);

    localparam logic [OP_W-1:0] OP_WRITE_WEIGHT = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_ERROR  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 1'b1;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             first;
        logic             last_row;
        logic [IDX_W-1:0] col;
        logic             last_col;
    } t_issue;

endpackage

// ===== rtl/core/tmv_ram.sv =====
`timescale 1ns / 1ps

module tmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tmv_seq.sv =====
`timescale 1ns / 1ps

module tmv_seq #(
    parameter int MAX_ROWS = tmv_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = tmv_pkg::DEF_MAX_COLS,
    parameter int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int WADDR_W  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tmv_pkg::CNT_W-1:0]  i_active_rows,
    input  logic [tmv_pkg::CNT_W-1:0]  i_active_cols,
    input  logic                       i_stall,
    output tmv_pkg::t_issue            o_issue,
    output logic                       o_busy,
    output logic [ROW_W-1:0]           o_eaddr,
    output logic [WADDR_W-1:0]         o_waddr
);

    localparam int COL_LIM = (MAX_COLS < tmv_pkg::RESULT_LIMIT) ? MAX_COLS
                                                                : tmv_pkg::RESULT_LIMIT;

    tmv_pkg::t_seq_state          r_state, n_state;
    logic [ROW_W-1:0]             r_row, n_row;
    logic [ROW_W-1:0]             r_row_last, n_row_last;
    logic [tmv_pkg::IDX_W-1:0]    r_col, n_col;
    logic [tmv_pkg::IDX_W-1:0]    r_col_last, n_col_last;
    logic [WADDR_W-1:0]           r_waddr, n_waddr;
    logic                         r_zero, n_zero;
    int                           rows_req;
    int                           cols_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmv_pkg::SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_row      <= n_row;
        r_row_last <= n_row_last;
        r_col      <= n_col;
        r_col_last <= n_col_last;
        r_waddr    <= n_waddr;
        r_zero     <= n_zero;
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_row_last = r_row_last;
        n_col      = r_col;
        n_col_last = r_col_last;
        n_waddr    = r_waddr;
        n_zero     = r_zero;
        rows_req   = int'(i_active_rows);
        cols_req   = int'(i_active_cols);

        o_issue.valid    = (r_state == tmv_pkg::SEQ_RUN);
        o_issue.zero     = r_zero;
        o_issue.first    = (r_row == '0);
        o_issue.last_row = r_zero || (r_row == r_row_last);
        o_issue.col      = r_col;
        o_issue.last_col = (r_col == r_col_last);

        case (r_state)
            tmv_pkg::SEQ_IDLE: begin
                if (i_start && cols_req != 0) begin
                    n_state = tmv_pkg::SEQ_RUN;
                    n_row   = '0;
                    n_col   = '0;
                    n_waddr = '0;
                    n_zero  = (rows_req == 0);
                    if (rows_req == 0) begin
                        n_row_last = '0;
                    end else if (rows_req > MAX_ROWS) begin
                        n_row_last = ROW_W'(MAX_ROWS - 1);
                    end else begin
                        n_row_last = ROW_W'(rows_req - 1);
                    end
                    if (cols_req > COL_LIM) begin
                        n_col_last = tmv_pkg::IDX_W'(COL_LIM - 1);
                    end else begin
                        n_col_last = tmv_pkg::IDX_W'(cols_req - 1);
                    end
                end
            end
            tmv_pkg::SEQ_RUN: begin
                if (!i_stall) begin
                    if (o_issue.last_row) begin
                        n_row   = '0;
                        n_col   = r_col + tmv_pkg::IDX_W'(1);
                        n_waddr = WADDR_W'(int'(r_col) + 1);
                        if (o_issue.last_col) begin
                            n_state = tmv_pkg::SEQ_IDLE;
                        end
                    end else begin
                        n_row   = r_row + ROW_W'(1);
                        n_waddr = r_waddr + WADDR_W'(MAX_COLS);
                    end
                end
            end
            default: begin
                n_state = tmv_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state == tmv_pkg::SEQ_RUN);
    assign o_eaddr = r_row;
    assign o_waddr = r_waddr;

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmv_pkg::SEQ_RUN) |-> (r_row <= r_row_last && r_col <= r_col_last))
        else $error("row or column counter ran past its limit");

endmodule

// ===== rtl/core/tmv_mac.sv =====
`timescale 1ns / 1ps

module tmv_mac #(
    parameter int MAX_ROWS  = tmv_pkg::DEF_MAX_ROWS,
    parameter int FRAC_BITS = tmv_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tmv_pkg::t_issue                   i_issue,
    input  logic [tmv_pkg::DATA_W-1:0]        i_err_data,
    input  logic [tmv_pkg::DATA_W-1:0]        i_w_data,
    input  logic                              i_out_ready,
    output logic                              o_stall,
    output logic                              o_busy,
    output logic                              o_out_valid,
    output logic [tmv_pkg::IDX_W-1:0]         o_hidden_index,
    output logic signed [tmv_pkg::DATA_W-1:0] o_hidden_error,
    output logic                              o_last
);

    localparam int PROD_W = 2 * tmv_pkg::DATA_W;
    localparam int ACC_W  = PROD_W + ((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 0) + 1;

    tmv_pkg::t_issue                   r_s1;
    tmv_pkg::t_issue                   r_s2;
    logic signed [PROD_W-1:0]          r_prod;
    logic signed [ACC_W-1:0]           r_acc;
    logic                              r_s3_done;
    logic [tmv_pkg::IDX_W-1:0]         r_s3_col;
    logic                              r_s3_last;
    logic                              r_out_valid;
    logic [tmv_pkg::IDX_W-1:0]         r_out_index;
    logic signed [tmv_pkg::DATA_W-1:0] r_out_error;
    logic                              r_out_last;

    logic signed [ACC_W-1:0]           acc_base;
    logic signed [ACC_W-1:0]           shifted;
    logic                              fits;
    logic signed [tmv_pkg::DATA_W-1:0] sat_value;

    assign o_stall = r_out_valid && !i_out_ready;

    always_comb begin
        acc_base = r_s2.first ? '0 : r_acc;
        shifted  = r_acc >>> FRAC_BITS;
        fits     = (&shifted[ACC_W-1:tmv_pkg::DATA_W-1]) ||
                   !(|shifted[ACC_W-1:tmv_pkg::DATA_W-1]);
        if (fits) begin
            sat_value = shifted[tmv_pkg::DATA_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            sat_value = {1'b1, {(tmv_pkg::DATA_W-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(tmv_pkg::DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid  <= 1'b0;
            r_s2.valid  <= 1'b0;
            r_s3_done   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_s1.valid <= i_issue.valid;
                r_s2.valid <= r_s1.valid;
                r_s3_done  <= r_s2.valid && r_s2.last_row;
            end
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= r_s3_done;
            end
        end
        if (!o_stall) begin
            r_s1.zero     <= i_issue.zero;
            r_s1.first    <= i_issue.first;
            r_s1.last_row <= i_issue.last_row;
            r_s1.col      <= i_issue.col;
            r_s1.last_col <= i_issue.last_col;
            r_s2.zero     <= r_s1.zero;
            r_s2.first    <= r_s1.first;
            r_s2.last_row <= r_s1.last_row;
            r_s2.col      <= r_s1.col;
            r_s2.last_col <= r_s1.last_col;
            if (r_s1.zero) begin
                r_prod <= '0;
            end else begin
                r_prod <= $signed(i_err_data) * $signed(i_w_data);
            end
            if (r_s2.valid) begin
                r_acc     <= acc_base + ACC_W'(r_prod);
                r_s3_col  <= r_s2.col;
                r_s3_last <= r_s2.last_col;
            end
        end
        if (!r_out_valid || i_out_ready) begin
            r_out_index <= r_s3_col;
            r_out_error <= sat_value;
            r_out_last  <= r_s3_last;
        end
    end

    assign o_busy         = r_s1.valid || r_s2.valid || r_s3_done;
    assign o_out_valid    = r_out_valid;
    assign o_hidden_index = r_out_index;
    assign o_hidden_error = r_out_error;
    assign o_last         = r_out_last;

    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_acc))
        else $error("accumulator changed while the pipeline was stalled");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && r_s3_done) |=> r_s3_done)
        else $error("finished sum was dropped while the output was full");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && r_s1.valid) |=> r_s2.valid)
        else $error("product stage lost a beat");

endmodule

// ===== rtl/core/transposed_matvec_error_backprop_unit.sv =====
`timescale 1ns / 1ps

// Computes hidden errors as the transposed weight matrix times the output
// error vector, in signed fixed point with FRAC_BITS fraction bits. Weight
// and error write beats are taken one per cycle while the block is idle and
// go straight into two single-port-write memories, which are never cleared,
// so every entry a compute beat reads must have been written first. A compute
// beat walks the weight memory one multiply-accumulate per cycle while the
// pipeline is not stalled, through a single read port and a single 32x32
// multiplier. With R the active row count limited to MAX_ROWS and taken as
// at least one, and C the active column count limited to MAX_COLS and to
// 16, a compute beat issues R * C multiply-accumulates. A compute beat with
// no active columns starts no pass and gives no result, like a write. Results
// come one per column in ascending order with last on the final one. The
// pipeline stalls while a result waits at the output. The block accepts the
// next beat once the final result sits in the output register. Configuration
// writes are registered and are read only when a compute pass starts.
module transposed_matvec_error_backprop_unit #(
    parameter int MAX_ROWS  = tmv_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = tmv_pkg::DEF_MAX_COLS,
    parameter int FRAC_BITS = tmv_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tmv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tmv_pkg::CNT_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tmv_pkg::OP_W-1:0]            i_operation,
    input  logic [tmv_pkg::IDX_W-1:0]           i_row,
    input  logic [tmv_pkg::IDX_W-1:0]           i_col,
    input  logic signed [tmv_pkg::DATA_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tmv_pkg::IDX_W-1:0]           o_hidden_index,
    output logic signed [tmv_pkg::DATA_W-1:0]   o_hidden_error,
    output logic                                o_last
);

    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WADDR_W = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

    logic [tmv_pkg::CNT_W-1:0]  r_active_rows;
    logic [tmv_pkg::CNT_W-1:0]  r_active_cols;

    logic                       in_accept;
    logic                       row_ok;
    logic                       col_ok;
    logic                       w_we;
    logic                       e_we;
    logic [WADDR_W-1:0]         w_waddr;
    logic [ROW_W-1:0]           e_waddr;
    logic                       start;

    tmv_pkg::t_issue            issue;
    logic                       seq_busy;
    logic                       mac_busy;
    logic                       stall;
    logic [ROW_W-1:0]           e_raddr;
    logic [WADDR_W-1:0]         w_raddr;
    logic [tmv_pkg::DATA_W-1:0] e_rdata;
    logic [tmv_pkg::DATA_W-1:0] w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_rows <= tmv_pkg::COUNT_RESET;
            r_active_cols <= tmv_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tmv_pkg::REG_ACTIVE_ROWS: r_active_rows <= i_cfg_data;
                tmv_pkg::REG_ACTIVE_COLS: r_active_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !seq_busy && !mac_busy;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        row_ok  = (int'(i_row) < MAX_ROWS);
        col_ok  = (int'(i_col) < MAX_COLS);
        w_we    = in_accept && (i_operation == tmv_pkg::OP_WRITE_WEIGHT) && row_ok && col_ok;
        e_we    = in_accept && (i_operation == tmv_pkg::OP_WRITE_ERROR) && row_ok;
        start   = in_accept && (i_operation == tmv_pkg::OP_COMPUTE);
        w_waddr = WADDR_W'(int'(i_row) * MAX_COLS + int'(i_col));
        e_waddr = ROW_W'(int'(i_row));
    end

    tmv_ram #(
        .WIDTH (tmv_pkg::DATA_W),
        .DEPTH (MAX_ROWS * MAX_COLS),
        .AW    (WADDR_W)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_rd_en (!stall),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tmv_ram #(
        .WIDTH (tmv_pkg::DATA_W),
        .DEPTH (MAX_ROWS),
        .AW    (ROW_W)
    ) u_error_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (i_value),
        .i_rd_en (!stall),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    tmv_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .ROW_W    (ROW_W),
        .WADDR_W  (WADDR_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_active_rows (r_active_rows),
        .i_active_cols (r_active_cols),
        .i_stall       (stall),
        .o_issue       (issue),
        .o_busy        (seq_busy),
        .o_eaddr       (e_raddr),
        .o_waddr       (w_raddr)
    );

    tmv_mac #(
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_issue        (issue),
        .i_err_data     (e_rdata),
        .i_w_data       (w_rdata),
        .i_out_ready    (i_out_ready),
        .o_stall        (stall),
        .o_busy         (mac_busy),
        .o_out_valid    (o_out_valid),
        .o_hidden_index (o_hidden_index),
        .o_hidden_error (o_hidden_error),
        .o_last         (o_last)
    );

    a_idle_no_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !issue.valid)
        else $error("input taken while a compute pass was still issuing");

endmodule

// ===== dv/tb_transposed_matvec_error_backprop_unit.sv =====
`timescale 1ns / 1ps

module tb_transposed_matvec_error_backprop_unit;

    localparam int OP_W = tmv_pkg::OP_W;
    localparam int IDX_W = tmv_pkg::IDX_W;
    localparam int DATA_W = tmv_pkg::DATA_W;
    localparam int CNT_W = tmv_pkg::CNT_W;
    localparam int CFG_IDX_W = tmv_pkg::CFG_IDX_W;
    localparam int RESULT_LIMIT = tmv_pkg::RESULT_LIMIT;
    localparam logic [CNT_W-1:0] COUNT_RESET = tmv_pkg::COUNT_RESET;
    localparam logic [OP_W-1:0] OP_WRITE_WEIGHT = tmv_pkg::OP_WRITE_WEIGHT;
    localparam logic [OP_W-1:0] OP_WRITE_ERROR = tmv_pkg::OP_WRITE_ERROR;
    localparam logic [OP_W-1:0] OP_COMPUTE = tmv_pkg::OP_COMPUTE;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = tmv_pkg::REG_ACTIVE_ROWS;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = tmv_pkg::REG_ACTIVE_COLS;

    localparam int NROWS = tmv_pkg::DEF_MAX_ROWS;
    localparam int NCOLS = tmv_pkg::DEF_MAX_COLS;
    localparam int FRAC = tmv_pkg::DEF_FRAC_BITS;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 20;
    localparam int END_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int MODE_ITEMS = 25;
    localparam logic signed [127:0] SAT_HI = 128'sh7fff_ffff;
    localparam logic signed [127:0] SAT_LO = -SAT_HI - 128'sd1;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] err;
        logic              last;
    } t_hidden;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  r;
        logic [IDX_W-1:0]  c;
        logic [DATA_W-1:0] v;
    } t_beat;

    typedef struct {
        bit                is_cfg;
        t_beat             beat;
        logic [CNT_W-1:0]  n_rows;
        logic [CNT_W-1:0]  n_cols;
        bit                pinned;
        logic [DATA_W-1:0] pin_err;
    } t_step;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CNT_W-1:0]         i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_operation = '0;
    logic [IDX_W-1:0]         i_row = '0;
    logic [IDX_W-1:0]         i_col = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [IDX_W-1:0]         o_hidden_index;
    logic signed [DATA_W-1:0] o_hidden_error;
    logic                     o_last;

    transposed_matvec_error_backprop_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hidden_index (o_hidden_index),
        .o_hidden_error (o_hidden_error),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    logic [DATA_W-1:0] weight_mem [NROWS*NCOLS];
    logic [DATA_W-1:0] err_mem [NROWS];
    logic [CNT_W-1:0]  rows_reg;
    logic [CNT_W-1:0]  cols_reg;
    t_hidden           hidden_q [$];
    t_hidden           want;
    int                outstanding = 0;
    int                n_fail = 0;
    int                n_push;
    int                n_pop;
    int                quiet_cycles = 0;
    bit                moved;
    logic [DATA_W-1:0] last_err_seen = '0;

    bit w_done [NROWS*NCOLS];
    bit e_done [NROWS];
    int tx_idle_pct = 13;
    int rx_idle_pct = 53;

    function automatic int clamp_to(int n, int top);
        return (n > top) ? top : n;
    endfunction

    function automatic logic [DATA_W-1:0] column_sum(int col, int n_rows);
        logic signed [127:0] acc;
        longint              prod;
        acc = '0;
        for (int r = 0; r < n_rows; r++) begin
            prod = longint'($signed(err_mem[r])) * longint'($signed(weight_mem[r*NCOLS+col]));
            acc += prod;
        end
        acc = acc >>> FRAC;
        if (acc > SAT_HI) return SAT_HI[DATA_W-1:0];
        if (acc < SAT_LO) return SAT_LO[DATA_W-1:0];
        return acc[DATA_W-1:0];
    endfunction

    function automatic int predict_hidden();
        int rows_eff;
        int cols_eff;
        t_hidden h;
        rows_eff = clamp_to(int'(rows_reg), NROWS);
        cols_eff = clamp_to(clamp_to(int'(cols_reg), NCOLS), RESULT_LIMIT);
        for (int c = 0; c < cols_eff; c++) begin
            h.index = IDX_W'(c);
            h.err = column_sum(c, rows_eff);
            h.last = (c == cols_eff - 1);
            hidden_q.push_back(h);
        end
        return cols_eff;
    endfunction

    function automatic void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                          logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            n_fail++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg = COUNT_RESET;
            cols_reg = COUNT_RESET;
            outstanding <= 0;
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            n_push = 0;
            n_pop = 0;
            if (i_cfg_we) begin
                moved = 1'b1;
                case (i_cfg_index)
                    REG_ACTIVE_ROWS: rows_reg = i_cfg_data;
                    REG_ACTIVE_COLS: cols_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                last_err_seen = o_hidden_error;
                if (hidden_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result beat, expected none, actual index %0d error %h",
                             $time, o_hidden_index, o_hidden_error);
                end else begin
                    want = hidden_q.pop_front();
                    n_pop = 1;
                    compare_field("hidden_index", DATA_W'(want.index), DATA_W'(o_hidden_index));
                    compare_field("hidden_error", want.err, o_hidden_error);
                    compare_field("last", DATA_W'(want.last), DATA_W'(o_last));
                end
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                case (i_operation)
                    OP_WRITE_WEIGHT: weight_mem[i_row*NCOLS+i_col] = i_value;
                    OP_WRITE_ERROR:  err_mem[i_row] = i_value;
                    OP_COMPUTE:      n_push = predict_hidden();
                    default: ;
                endcase
            end
            outstanding <= outstanding + n_push - n_pop;
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    task automatic send_beat(input t_beat b);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_operation <= b.op;
        i_row <= b.r;
        i_col <= b.c;
        i_value <= b.v;
        do @(posedge i_clk); while (!o_in_ready);
        if (b.op == OP_WRITE_WEIGHT) w_done[b.r*NCOLS+b.c] = 1'b1;
        if (b.op == OP_WRITE_ERROR) e_done[b.r] = 1'b1;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_counts(input logic [CNT_W-1:0] nr, input logic [CNT_W-1:0] nc);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_ACTIVE_ROWS;
        i_cfg_data <= nr;
        @(posedge i_clk);
        i_cfg_index <= REG_ACTIVE_COLS;
        i_cfg_data <= nc;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_step cfg_step(logic [CNT_W-1:0] nr, logic [CNT_W-1:0] nc);
        t_step s;
        s.is_cfg = 1'b1;
        s.beat = '0;
        s.n_rows = nr;
        s.n_cols = nc;
        s.pinned = 1'b0;
        s.pin_err = '0;
        return s;
    endfunction

    function automatic t_step item_step(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
                                        logic [IDX_W-1:0] c, logic [DATA_W-1:0] v);
        t_step s;
        s.is_cfg = 1'b0;
        s.beat = '{op, r, c, v};
        s.n_rows = '0;
        s.n_cols = '0;
        s.pinned = 1'b0;
        s.pin_err = '0;
        return s;
    endfunction

    function automatic t_step sum_step(bit pinned, logic [DATA_W-1:0] pin_err);
        t_step s;
        s = item_step(OP_COMPUTE, '0, '0, '0);
        s.pinned = pinned;
        s.pin_err = pin_err;
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int k;
        k = $urandom_range(0, 99);
        if (k < 8) return '0;
        if (k < 55) return CNT_W'($urandom_range(1, 4));
        if (k < 75) return CNT_W'($urandom_range(5, 15));
        if (k < 88) return CNT_W'(16);
        return CNT_W'($urandom_range(17, 31));
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        int k;
        k = $urandom_range(0, 99);
        if (k < 35) return $urandom();
        if (k < 80) return DATA_W'(int'($urandom_range(0, 20'hf_ffff)) - 32'sh8_0000);
        case ($urandom_range(0, 4))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic t_beat rand_beat(logic [OP_W-1:0] op);
        t_beat b;
        b.op = op;
        b.r = IDX_W'($urandom_range(0, 15));
        b.c = IDX_W'($urandom_range(0, 15));
        b.v = rand_value();
        return b;
    endfunction

    // Writes every entry the next compute will read that was never written, plus
    // some random rewrites and noise, in shuffled order, then computes.
    task automatic run_episode(input bit full, output int n_sent);
        logic [CNT_W-1:0] rq;
        logic [CNT_W-1:0] cq;
        int               re;
        int               ce;
        int               need;
        int               j;
        t_beat            b;
        t_beat            tmp;
        t_beat            plan [$];
        rq = full ? CNT_W'(2) : pick_count();
        cq = full ? CNT_W'(16) : pick_count();
        re = clamp_to(int'(rq), NROWS);
        ce = clamp_to(clamp_to(int'(cq), NCOLS), RESULT_LIMIT);
        need = 0;
        for (int r = 0; r < re; r++)
            for (int c = 0; c < ce; c++)
                if (!w_done[r*NCOLS+c]) need++;
        if (!full && need > 48) begin
            cq = CNT_W'($urandom_range(1, 3));
            ce = int'(cq);
        end
        set_counts(rq, cq);
        for (int r = 0; r < re; r++) begin
            if (!e_done[r]) begin
                b = rand_beat(OP_WRITE_ERROR);
                b.r = IDX_W'(r);
                plan.push_back(b);
            end
            for (int c = 0; c < ce; c++) begin
                if (!w_done[r*NCOLS+c]) begin
                    b = rand_beat(OP_WRITE_WEIGHT);
                    b.r = IDX_W'(r);
                    b.c = IDX_W'(c);
                    plan.push_back(b);
                end
            end
        end
        repeat ($urandom_range(1, 6)) plan.push_back(rand_beat(OP_W'($urandom_range(0, 1))));
        if ($urandom_range(0, 9) == 0) plan.push_back(rand_beat(OP_UNUSED));
        for (int k = plan.size() - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = plan[k];
            plan[k] = plan[j];
            plan[j] = tmp;
        end
        plan.push_back(rand_beat(OP_COMPUTE));
        if ($urandom_range(0, 7) == 0) plan.push_back(rand_beat(OP_COMPUTE));
        n_sent = 0;
        foreach (plan[k]) begin
            send_beat(plan[k]);
            if (plan[k].op != OP_UNUSED) n_sent++;
        end
    endtask

    initial begin
        t_step directed [$];
        int    sent;
        int    mode_items;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(cfg_step(CNT_W'(1), CNT_W'(1)));
        directed.push_back(item_step(OP_WRITE_WEIGHT, 4'd0, 4'd0, 32'h7fff_ffff));
        directed.push_back(item_step(OP_WRITE_ERROR, 4'd0, 4'd0, 32'h7fff_ffff));
        directed.push_back(sum_step(1'b1, 32'h7fff_ffff));
        directed.push_back(item_step(OP_WRITE_WEIGHT, 4'd0, 4'd0, 32'h8000_0000));
        directed.push_back(sum_step(1'b1, 32'h8000_0000));
        directed.push_back(item_step(OP_WRITE_ERROR, 4'd0, 4'd0, 32'h8000_0000));
        directed.push_back(sum_step(1'b1, 32'h7fff_ffff));
        directed.push_back(item_step(OP_WRITE_WEIGHT, 4'd0, 4'd0, 32'h0001_0000));
        directed.push_back(item_step(OP_WRITE_ERROR, 4'd0, 4'd0, 32'h0001_0000));
        directed.push_back(sum_step(1'b1, 32'h0001_0000));
        directed.push_back(item_step(OP_WRITE_ERROR, 4'd0, 4'd0, 32'hffff_ffff));
        directed.push_back(sum_step(1'b1, 32'hffff_ffff));
        directed.push_back(item_step(OP_WRITE_WEIGHT, 4'd0, 4'd0, 32'h0000_0001));
        directed.push_back(item_step(OP_WRITE_ERROR, 4'd0, 4'd0, 32'h0000_0001));
        directed.push_back(sum_step(1'b1, 32'h0000_0000));
        directed.push_back(item_step(OP_WRITE_ERROR, 4'd0, 4'd0, 32'hffff_ffff));
        directed.push_back(sum_step(1'b1, 32'hffff_ffff));
        directed.push_back(item_step(OP_WRITE_WEIGHT, 4'd15, 4'd15, 32'h5a5a_5a5a));
        directed.push_back(item_step(OP_WRITE_ERROR, 4'd15, 4'd15, 32'ha5a5_a5a5));
        directed.push_back(item_step(OP_UNUSED, 4'd15, 4'd15, 32'hffff_ffff));
        directed.push_back(item_step(OP_WRITE_WEIGHT, 4'd0, 4'd1, 32'hc000_0000));
        directed.push_back(cfg_step(CNT_W'(1), CNT_W'(2)));
        directed.push_back(sum_step(1'b0, '0));
        directed.push_back(cfg_step(CNT_W'(0), CNT_W'(1)));
        directed.push_back(sum_step(1'b1, 32'h0000_0000));
        directed.push_back(cfg_step(CNT_W'(1), CNT_W'(0)));
        directed.push_back(sum_step(1'b0, '0));

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                set_counts(directed[k].n_rows, directed[k].n_cols);
            end else begin
                send_beat(directed[k].beat);
                if (directed[k].pinned) begin
                    wait_idle();
                    compare_field("directed hidden_error", directed[k].pin_err, last_err_seen);
                end
            end
        end

        for (int m = 0; m < 3; m++) begin
            tx_idle_pct = (m == 0) ? 13 : (m == 1) ? 53 : 0;
            rx_idle_pct = (m == 0) ? 53 : (m == 1) ? 13 : 0;
            mode_items = 0;
            while (mode_items < MODE_ITEMS) begin
                run_episode(1'b0, sent);
                mode_items += sent;
            end
        end
        run_episode(1'b1, sent);

        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
